// ===== sv/hnc_pkg.sv =====
// Shared types and constants for the height-map normal generator.
// No dependencies; imported by the top, front and back modules and the testbench.
`timescale 1ns / 1ps
package hnc_pkg;

  localparam int unsigned HEIGHT_W = 20;
  localparam int unsigned NX_W     = 16;
  localparam int unsigned NZ_W     = 15;
  localparam int unsigned COLUMN_W = 11;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned GW_W     = 12;

  localparam logic [14:0] ONE_Q14 = 15'd16384;
  localparam logic [9:0]  Z_UNITS = 10'd512;
  // 512^2, the z term of the squared length
  localparam logic [41:0] Z_SQ    = 42'd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 4'd0,
    REG_GRID_HEIGHT = 4'd1
  } cfg_reg_e;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_PICK = 12'b000000000010,
    S_READ = 12'b000000000100,
    S_DIFF = 12'b000000001000,
    S_SQX  = 12'b000000010000,
    S_SQY  = 12'b000000100000,
    S_MM   = 12'b000001000000,
    S_STEP = 12'b000010000000,
    S_MLO  = 12'b000100000000,
    S_MHI  = 12'b001000000000,
    S_CMP  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } back_state_e;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_e;

  // row slots cycle 0,1,2
  function automatic logic [1:0] slot_next(input logic [1:0] s);
    slot_next = (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    slot_prev = (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

// ===== sv/heightmap_normal_central_diff_top.sv =====
// Top level of the height-map normal generator (central differences).
// Depends on hnc_pkg, hnc_front, hnc_queue and hnc_back.
//
// Usage:
//  - Input channel: in_valid_i / in_stall_o carry one height word (signed
//    Q12.8) per accepted cycle, raster order, row 0 and column 0 first.
//  - Output channel: out_valid_o / out_stall_i carry one normal word: x, y
//    (signed Q1.14), z (Q1.14), its column, row and a last flag marking the
//    final result caused by one input word. A word may cause 0 to 3 results.
//  - Config: cfg_we_i writes grid_width (index 0) or grid_height (index 1)
//    and restarts the frame. Write only when the block is idle.
//  - Words go through a four-deep queue; the front takes a word per cycle
//    until it is full. The back does one point at a time: pick, fetch and
//    squares, three searches (set-up, up to 15 steps, close) and an output
//    state that holds while stalled; it pops no new word until it is done
//    with all results of the last one.
//  - Reset clears counters, queue and sequencer; the line store is not
//    cleared, as only rows of the current frame are ever read.
//  - A stalled result holds on the output; the queue keeps filling meanwhile.
`timescale 1ns / 1ps
module heightmap_normal_central_diff_top
  import hnc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [HEIGHT_W-1:0]   height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [NX_W-1:0]       normal_x_o,
  output logic [NX_W-1:0]       normal_y_o,
  output logic [NZ_W-1:0]       normal_z_o,
  output logic [COLUMN_W-1:0]   column_o,
  output logic [ROW_W-1:0]      grid_row_o,
  output logic                  last_o
);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  // sample, column, row, slot, three emit flags
  localparam int unsigned DW = HEIGHT_W + CW + ROW_W + 2 + 3;

  logic [GW_W-1:0]  gw_q;
  logic [ROW_W-1:0] gh_q;
  logic [WW-1:0]    width_eff;
  logic [ROW_W:0]   height_eff;
  logic             restart, accept, q_full, q_empty, q_pop;
  logic [DW-1:0]    entry_in, entry_out;

  // register writes; an unknown index is ignored
  assign restart = cfg_we_i &&
    (cfg_idx_i == REG_GRID_WIDTH || cfg_idx_i == REG_GRID_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GW_W'(256);
      gh_q <= ROW_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  gw_q <= cfg_data_i[GW_W-1:0];
        REG_GRID_HEIGHT: gh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize width saturates
  always_comb begin
    if (gw_q == '0) width_eff = WW'(1);
    else if (32'(gw_q) > MAX_WIDTH) width_eff = WW'(MAX_WIDTH);
    else width_eff = WW'(gw_q);
    height_eff = (gh_q == '0) ? (ROW_W + 1)'(1) : (ROW_W + 1)'(gh_q);
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  hnc_front #(.CW(CW), .WW(WW), .DW(DW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .width_i   (width_eff),
    .height_i  (height_eff),
    .accept_i  (accept),
    .sample_i  (height_i),
    .entry_o   (entry_in)
  );

  hnc_queue #(.DW(DW), .DEPTH(4)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (entry_in),
    .pop_i       (q_pop),
    .pop_data_o  (entry_out),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  hnc_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .WW(WW), .DW(DW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .empty_i     (q_empty),
    .entry_i     (entry_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o),
    .column_o    (column_o),
    .grid_row_o  (grid_row_o),
    .last_o      (last_o)
  );
endmodule

// ===== sv/hnc_queue.sv =====
// Small register FIFO between the front and back parts.
// Depends on nothing; width set by parameter.
`timescale 1ns / 1ps
module hnc_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o,
  output logic          full_o,
  output logic          empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end
endmodule

// ===== sv/hnc_front.sv =====
// Front part: raster position tracking and classification of each sample.
// Depends on hnc_pkg; feeds hnc_queue.
`timescale 1ns / 1ps
module hnc_front
  import hnc_pkg::*;
#(
  parameter int unsigned CW = 11,
  parameter int unsigned WW = 12,
  parameter int unsigned DW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [WW-1:0]       width_i,
  input  logic [ROW_W:0]      height_i,
  input  logic                accept_i,
  input  logic [HEIGHT_W-1:0] sample_i,
  output logic [DW-1:0]       entry_o
);
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       slot_q, slot_d;
  logic             row_end, last_row, emit_up, emit_left, emit_self;

  assign row_end   = (WW'(col_q) + WW'(1)) == width_i;
  assign last_row  = ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1)) == height_i;
  assign emit_up   = (row_q != '0);
  assign emit_left = last_row && (col_q != '0);
  assign emit_self = last_row && row_end;

  assign entry_o = {sample_i, col_q, row_q, slot_q, emit_up, emit_left, emit_self};

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      slot_d = '0;
    end else if (accept_i) begin
      if (row_end) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + ROW_W'(1);
          slot_d = slot_next(slot_q);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end
endmodule

// ===== sv/hnc_back.sv =====
// Back part: line store, slope fetch and iterative normalisation.
// Depends on hnc_pkg; drains hnc_queue and drives the result word.
`timescale 1ns / 1ps
module hnc_back
  import hnc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CW = 11,
  parameter int unsigned WW = 12,
  parameter int unsigned DW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WW-1:0]        width_i,
  input  logic [ROW_W:0]       height_i,
  input  logic                 empty_i,
  input  logic [DW-1:0]        entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [NX_W-1:0]      normal_x_o,
  output logic [NX_W-1:0]      normal_y_o,
  output logic [NZ_W-1:0]      normal_z_o,
  output logic [COLUMN_W-1:0]  column_o,
  output logic [ROW_W-1:0]     grid_row_o,
  output logic                 last_o
);
  localparam int unsigned AW = $clog2(3 * MAX_WIDTH);

  function automatic logic [AW-1:0] addr_of(input logic [1:0] s, input logic [CW-1:0] c);
    addr_of = AW'(s) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  logic [HEIGHT_W-1:0] mem [3 * MAX_WIDTH];
  logic [HEIGHT_W-1:0] rd_q;
  logic [AW-1:0]       raddr;

  back_state_e state_q;

  // latched queue entry
  logic [HEIGHT_W-1:0] e_h;
  logic [CW-1:0]       e_c;
  logic [ROW_W-1:0]    e_r;
  logic [1:0]          e_s;
  logic [2:0]          e_em;
  logic [CW-1:0]       ec_q;
  logic [ROW_W-1:0]    er_q;
  logic [1:0]          es_q;
  logic [2:0]          pend_q;

  // current point
  logic [CW-1:0]    pc_q;
  logic [ROW_W-1:0] pr_q;
  logic [1:0]       ps_q;
  logic             plast_q;
  logic [2:0]       rk_q;
  logic signed [HEIGHT_W-1:0] hxr_q, hxl_q, hyt_q, hyb_q;
  logic signed [HEIGHT_W:0]   dx_q, dy_q;
  logic [HEIGHT_W-1:0] mx_q, my_q;
  logic [41:0] s_q;
  logic [39:0] m_q;
  comp_e       comp_q;
  logic [14:0] lo_q, hi_q, mid_q, qx_q, qy_q;
  logic [29:0] tt_q;
  logic [50:0] plo_q, phi_q;

  logic [NX_W-1:0]     nx_q, ny_q;
  logic [NZ_W-1:0]     nz_q;
  logic [COLUMN_W-1:0] col_q;
  logic [ROW_W-1:0]    row_q;
  logic                last_q;

  logic [CW-1:0]  xl, xr;
  logic [1:0]     syb, syt;
  logic [14:0]    mid_n;
  logic [15:0]    t_n;
  logic [71:0]    prod, rhs;
  logic [HEIGHT_W-1:0] mag_n;

  assign {e_h, e_c, e_r, e_s, e_em} = entry_i;
  assign pop_o = (state_q == S_IDLE) && !empty_i;

  assign xl  = (pc_q != '0) ? pc_q - CW'(1) : pc_q;
  assign xr  = ((WW + 1)'(pc_q) + (WW + 1)'(1) < (WW + 1)'(width_i)) ? pc_q + CW'(1) : pc_q;
  assign syb = (pr_q != '0) ? slot_prev(ps_q) : ps_q;
  assign syt = ((ROW_W + 1)'(pr_q) + (ROW_W + 1)'(1) < height_i) ? slot_next(ps_q) : ps_q;

  always_comb begin
    case (rk_q)
      3'd0:    raddr = addr_of(ps_q, xr);
      3'd1:    raddr = addr_of(ps_q, xl);
      3'd2:    raddr = addr_of(syt, pc_q);
      default: raddr = addr_of(syb, pc_q);
    endcase
  end

  assign mid_n = 15'((16'(lo_q) + 16'(hi_q) + 16'd1) >> 1);
  assign t_n   = {mid_q, 1'b0} - 16'd1;
  assign prod  = {phi_q, 21'b0} + 72'(plo_q);
  assign rhs   = {2'b0, m_q, 30'b0};

  always_comb begin
    case (comp_q)
      COMP_X:  mag_n = mx_q;
      COMP_Y:  mag_n = my_q;
      default: mag_n = HEIGHT_W'(Z_UNITS);
    endcase
  end

  // line store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (pop_o) mem[addr_of(e_s, e_c)] <= e_h;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= '0;
      rk_q    <= '0;
      comp_q  <= COMP_X;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            pend_q  <= e_em;
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          rk_q <= '0;
          if (pend_q[2]) begin
            pend_q[2] <= 1'b0;
            state_q   <= S_READ;
          end else if (pend_q[1]) begin
            pend_q[1] <= 1'b0;
            state_q   <= S_READ;
          end else if (pend_q[0]) begin
            pend_q[0] <= 1'b0;
            state_q   <= S_READ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          rk_q <= rk_q + 3'd1;
          if (rk_q == 3'd4) state_q <= S_DIFF;
        end
        S_DIFF:  state_q <= S_SQX;
        S_SQX:   state_q <= S_SQY;
        S_SQY: begin
          comp_q  <= COMP_X;
          state_q <= S_MM;
        end
        S_MM:    state_q <= S_STEP;
        S_STEP: begin
          if (lo_q < hi_q) begin
            state_q <= S_MLO;
          end else begin
            case (comp_q)
              COMP_X: begin
                comp_q  <= COMP_Y;
                state_q <= S_MM;
              end
              COMP_Y: begin
                comp_q  <= COMP_Z;
                state_q <= S_MM;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_MLO:   state_q <= S_MHI;
        S_MHI:   state_q <= S_CMP;
        S_CMP:   state_q <= S_STEP;
        S_OUT: begin
          if (!out_stall_i) state_q <= S_PICK;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ec_q <= e_c;
        er_q <= e_r;
        es_q <= e_s;
      end
      S_PICK: begin
        // point above the new sample, then its left neighbour, then itself
        if (pend_q[2]) begin
          pc_q <= ec_q;
          pr_q <= er_q - ROW_W'(1);
          ps_q <= slot_prev(es_q);
          plast_q <= (pend_q[1:0] == 2'b00);
        end else if (pend_q[1]) begin
          pc_q <= ec_q - CW'(1);
          pr_q <= er_q;
          ps_q <= es_q;
          plast_q <= !pend_q[0];
        end else begin
          pc_q <= ec_q;
          pr_q <= er_q;
          ps_q <= es_q;
          plast_q <= 1'b1;
        end
      end
      S_READ: begin
        case (rk_q)
          3'd1:    hxr_q <= rd_q;
          3'd2:    hxl_q <= rd_q;
          3'd3:    hyt_q <= rd_q;
          3'd4:    hyb_q <= rd_q;
          default: ;
        endcase
      end
      S_DIFF: begin
        dx_q <= (HEIGHT_W + 1)'(hxr_q) - (HEIGHT_W + 1)'(hxl_q);
        dy_q <= (HEIGHT_W + 1)'(hyt_q) - (HEIGHT_W + 1)'(hyb_q);
      end
      S_SQX: begin
        mx_q <= HEIGHT_W'(dx_q[HEIGHT_W] ? -dx_q : dx_q);
        my_q <= HEIGHT_W'(dy_q[HEIGHT_W] ? -dy_q : dy_q);
      end
      S_SQY: begin
        s_q <= 42'(mx_q * mx_q) + 42'(my_q * my_q) + Z_SQ;
      end
      S_MM: begin
        m_q  <= 40'(mag_n * mag_n);
        lo_q <= '0;
        hi_q <= ONE_Q14;
      end
      S_STEP: begin
        if (lo_q < hi_q) begin
          mid_q <= mid_n;
        end else begin
          case (comp_q)
            COMP_X:  qx_q <= lo_q;
            COMP_Y:  qy_q <= lo_q;
            default: begin
              nx_q   <= (dx_q > 0) ? -{1'b0, qx_q} : {1'b0, qx_q};
              ny_q   <= (dy_q > 0) ? -{1'b0, qy_q} : {1'b0, qy_q};
              nz_q   <= lo_q;
              col_q  <= COLUMN_W'(pc_q);
              row_q  <= pr_q;
              last_q <= plast_q;
            end
          endcase
        end
      end
      S_MLO: begin
        tt_q  <= 30'(t_n * t_n);
      end
      S_MHI: begin
        plo_q <= 51'(tt_q * s_q[20:0]);
        phi_q <= 51'(tt_q * s_q[41:21]);
      end
      S_CMP: begin
        if (prod <= rhs) lo_q <= mid_q;
        else hi_q <= mid_q - 15'd1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = (state_q == S_OUT);
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign column_o    = col_q;
  assign grid_row_o  = row_q;
  assign last_o      = last_q;

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (lo_q <= hi_q && hi_q <= ONE_Q14))
    else $error("search bounds crossed");
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (pend_q == 3'b000))
    else $error("points left over at idle");
  a_out_then_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (state_q == S_PICK))
    else $error("result taken but no next point");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_PICK))
    else $error("queue popped outside idle");
endmodule

// ===== tb/tb_heightmap_normal_central_diff_top.sv =====
// Testbench for heightmap_normal_central_diff_top: directed and random height maps.
// Depends on hnc_pkg and the block's RTL; predicts each normal word and checks it.
`timescale 1ns / 1ps
module tb_heightmap_normal_central_diff_top;
  import hnc_pkg::*;

  localparam int unsigned MAXW = 2048;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TWO   = 4'd2;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [NX_W-1:0]     nx;
    logic [NX_W-1:0]     ny;
    logic [NZ_W-1:0]     nz;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
    logic                last;
  } normal_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [HEIGHT_W-1:0]   height_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [NX_W-1:0]       normal_x_o;
  logic [NX_W-1:0]       normal_y_o;
  logic [NZ_W-1:0]       normal_z_o;
  logic [COLUMN_W-1:0]   column_o;
  logic [ROW_W-1:0]      grid_row_o;
  logic                  last_o;

  heightmap_normal_central_diff_top dut (.*);

  // predictor state
  logic [HEIGHT_W-1:0] line_rows [3*MAXW];
  int unsigned cur_col, cur_row;
  logic [GW_W-1:0] width_reg;
  logic [ROW_W-1:0] height_reg;
  normal_word_t normals_due [$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  bit quiet = 0;        // no idling on either side while set
  longint unsigned cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [31:0] stored_height(int unsigned c, int unsigned r);
    stored_height = $signed(line_rows[(r % 3) * MAXW + c]);
  endfunction

  // round(mag * 2^14 / sqrt(s)), ties away from zero, by exact search
  function automatic logic [14:0] unit_scale(logic [63:0] mag, logic [63:0] s);
    logic [127:0] rhs, lhs, t;
    int unsigned lo, hi, mid;
    rhs = ({64'd0, mag} * {64'd0, mag}) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = t * t * {64'd0, s};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    unit_scale = lo[14:0];
  endfunction

  function automatic logic [15:0] signed_unit(logic signed [31:0] v, logic [63:0] s);
    logic [63:0] mag;
    logic [15:0] q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = {1'b0, unit_scale(mag, s)};
    signed_unit = (v < 0) ? -q : q;
  endfunction

  function automatic normal_word_t point_normal(int unsigned c, int unsigned r,
                                                int unsigned w, int unsigned h);
    int unsigned xl, xr, yb, yt;
    logic signed [31:0] dx, dy;
    logic [63:0] s;
    normal_word_t n;
    xl = (c > 0) ? c - 1 : c;
    xr = (c + 1 < w) ? c + 1 : c;
    yb = (r > 0) ? r - 1 : r;
    yt = (r + 1 < h) ? r + 1 : r;
    dx = stored_height(xr, r) - stored_height(xl, r);
    dy = stored_height(c, yt) - stored_height(c, yb);
    s = 64'(longint'(dx) * dx) + 64'(longint'(dy) * dy) + 64'd262144;
    n.nx = signed_unit(-dx, s);
    n.ny = signed_unit(-dy, s);
    n.nz = unit_scale(64'd512, s);
    n.col = c[COLUMN_W-1:0];
    n.row = r[ROW_W-1:0];
    n.last = 1'b0;
    return n;
  endfunction

  // one accepted height word: store it and queue the normals it releases
  task automatic predict_normals(logic [HEIGHT_W-1:0] hv);
    int unsigned w, h, c, r, k, first;
    normal_word_t n;
    w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    c = cur_col;
    r = cur_row;
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end
    line_rows[(r % 3) * MAXW + c] = hv;
    first = normals_due.size();
    if (r >= 1) normals_due.push_back(point_normal(c, r - 1, w, h));
    if (r + 1 == h) begin
      if (c >= 1) normals_due.push_back(point_normal(c - 1, r, w, h));
      if (c + 1 == w) normals_due.push_back(point_normal(c, r, w, h));
    end
    k = normals_due.size();
    if (k > first) begin
      n = normals_due[k-1];
      n.last = 1'b1;
      normals_due[k-1] = n;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_col = c;
    cur_row = r;
  endtask

  // called at a rising edge; leaves valid high so back-to-back words need no toggle
  task automatic send_height(logic [HEIGHT_W-1:0] hv);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i <= hv;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_normals(hv);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_GRID_WIDTH) width_reg = val[GW_W-1:0];
    else if (idx == REG_GRID_HEIGHT) height_reg = val;
    if (idx == REG_GRID_WIDTH || idx == REG_GRID_HEIGHT) begin
      cur_col = 0;
      cur_row = 0;
    end
  endtask

  task automatic set_grid(int unsigned w, int unsigned h);
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic logic [HEIGHT_W-1:0] random_height();
    if ($urandom_range(0, 1)) return HEIGHT_W'($urandom);
    return HEIGHT_W'(32'sd2000 - $signed($urandom_range(0, 4000)));
  endfunction

  // result checker and output-side idling
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    normal_word_t got, want;
    if (out_valid_o && !out_stall_i) begin
      got = '{normal_x_o, normal_y_o, normal_z_o, column_o, grid_row_o, last_o};
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, got);
        errors++;
      end else begin
        want = normals_due.pop_front();
        if (got.nx != want.nx) begin
          $display("%0t: normal_x expected %h actual %h", $time, want.nx, got.nx); errors++;
        end
        if (got.ny != want.ny) begin
          $display("%0t: normal_y expected %h actual %h", $time, want.ny, got.ny); errors++;
        end
        if (got.nz != want.nz) begin
          $display("%0t: normal_z expected %h actual %h", $time, want.nz, got.nz); errors++;
        end
        if (got.col != want.col) begin
          $display("%0t: column expected %0d actual %0d", $time, want.col, got.col); errors++;
        end
        if (got.row != want.row) begin
          $display("%0t: grid_row expected %0d actual %0d", $time, want.row, got.row); errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last); errors++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 3);
    end
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // full-scale heights on a 3x3 grid: steepest slopes both ways
  task automatic test_height_extremes();
    logic [HEIGHT_W-1:0] pat [9];
    pat = '{20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h00000,
            20'h7FFFF, 20'h80000, 20'h7FFFF, 20'hFFFFF};
    set_grid(3, 3);
    foreach (pat[i]) send_height(pat[i]);
  endtask

  // a lone column and a lone row leave one slope at zero, a single point both
  task automatic test_single_row_column();
    set_grid(1, 4);
    repeat (4) send_height(random_height());
    set_grid(4, 1);
    repeat (4) send_height(random_height());
    set_grid(1, 1);
    repeat (2) send_height(random_height());
  endtask

  // zero and oversized register values, and writes to unused indexes
  task automatic test_register_clamps();
    write_reg(REG_GRID_WIDTH, 16'h0000);
    write_reg(REG_GRID_HEIGHT, 16'h0000);
    repeat (2) send_height(random_height());
    write_reg(REG_GRID_WIDTH, 16'hFFFF);   // low 12 bits 4095, clamps to full width
    write_reg(REG_GRID_HEIGHT, 16'd1);
    repeat (12) send_height(random_height());
    write_reg(REG_GRID_WIDTH, 16'd2);
    write_reg(REG_GRID_HEIGHT, 16'hFFFF);
    repeat (6) send_height(random_height());
    write_reg(CFG_IDX_SPARE, 16'hA5A5);    // no effect, frame carries on
    write_reg(CFG_IDX_TWO, 16'h5A5A);
    repeat (4) send_height(random_height());
  endtask

  // widest legal row, only a few words of it
  task automatic test_full_width();
    set_grid(2048, 1);
    repeat (8) send_height(random_height());
  endtask

  // random small grids: whole frames, wrapped frames and cut-off frames
  task automatic test_random_frames();
    int unsigned w, h, n;
    while (words_sent < 300) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      set_grid(w, h);
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0: n = $urandom_range(1, w * h);
        1: n = w * h + $urandom_range(1, w * h);
        default: n = w * h;
      endcase
      repeat (n) send_height(random_height());
      quiet = 0;
    end
  endtask

  initial begin
    width_reg = 12'd256;
    height_reg = 16'd256;
    cur_col = 0;
    cur_row = 0;
    foreach (line_rows[i]) line_rows[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_height_extremes();
    test_single_row_column();
    test_register_clamps();
    test_full_width();
    test_random_frames();
    wait_idle();
    if (errors == 0 || normals_due.size() != 0) begin
      if (errors == 0 && normals_due.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== heightmap_normal_central_diff_top.f =====
sv/hnc_pkg.sv
sv/hnc_queue.sv
sv/hnc_front.sv
sv/hnc_back.sv
sv/heightmap_normal_central_diff_top.sv
tb/tb_heightmap_normal_central_diff_top.sv
